// File: hdl/pngsu_pkg.sv
// Shared types and constants for the PNG Sub/Up row unfilter.
package pngsu_pkg;

    localparam int DEF_MAX_ROW_PIXELS = 4096;
    localparam int DEF_LANES          = 8;
    localparam int PORT_LANES         = 8;
    localparam int BPP_W              = 4;
    localparam logic [BPP_W-1:0] BPP_RESET = 4'd4;
    localparam int QUEUE_DEPTH        = 2;
    localparam int APB_AW             = 3;
    localparam int APB_DW             = 32;
    localparam logic REG_BPP          = 1'b0;

    typedef logic [PORT_LANES-1:0][7:0] lane_bytes_t;

    typedef enum logic [1:0] {
        PRED_LEFT  = 2'd0,
        PRED_STORE = 2'd1,
        PRED_ZERO  = 2'd2
    } pred_sel_t;

    typedef struct packed {
        pred_sel_t pred_sel;
        logic      last;
        logic      ovf;
    } pix_ctrl_t;

endpackage

// File: hdl/pngsu_front.sv
// Front end: accepts pixels, tracks row position and picks the predictor source.
module pngsu_front #(
    parameter int MAX_ROW_PIXELS = 4096,
    parameter int PW = 13,
    parameter int AW = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pngsu_pkg::lane_bytes_t in_bytes,
    input  logic                 filter_kind,
    input  logic                 first_row,
    input  logic                 last_in_row,
    input  logic                 busy,
    input  logic                 q_ready,
    output logic                 q_push,
    output pngsu_pkg::lane_bytes_t q_bytes,
    output pngsu_pkg::pix_ctrl_t q_ctrl,
    output logic [AW-1:0]        q_addr
);
    import pngsu_pkg::*;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          ovf;

    assign ovf      = (pos_reg >= PW'(MAX_ROW_PIXELS));
    assign in_ready = q_ready && !busy;
    assign q_push   = in_valid && in_ready;
    assign q_bytes  = in_bytes;
    assign q_addr   = pos_reg[AW-1:0];

    always_comb
    begin
        q_ctrl.last = last_in_row;
        q_ctrl.ovf  = ovf;
        if (!filter_kind)
            q_ctrl.pred_sel = PRED_LEFT;
        else if (first_row || ovf)
            q_ctrl.pred_sel = PRED_ZERO;
        else
            q_ctrl.pred_sel = PRED_STORE;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (q_push)
        begin
            if (last_in_row)
                pos_next = '0;
            else if (!ovf)
                pos_next = pos_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_ROW_PIXELS))
        else $error("row position past saturation");
    a_row_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && last_in_row) |=> (pos_reg == '0))
        else $error("row position not cleared after row end");
`endif

endmodule

// File: hdl/pngsu_fifo.sv
// Short word queue between the front end and the back end.
module pngsu_fifo #(
    parameter int W = 80
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);
    import pngsu_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count past depth");
`endif

endmodule

// File: hdl/pngsu_back.sv
// Back end: line store, predictor add and output register.
module pngsu_back #(
    parameter int MAX_ROW_PIXELS = 4096,
    parameter int LANES = 8,
    parameter int AW = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [pngsu_pkg::BPP_W-1:0] bpp,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  pngsu_pkg::lane_bytes_t   q_bytes,
    input  pngsu_pkg::pix_ctrl_t     q_ctrl,
    input  logic [AW-1:0]            q_addr,
    output logic                     busy,
    output logic                     out_valid,
    input  logic                     out_ready,
    output pngsu_pkg::lane_bytes_t   out_bytes,
    output logic                     row_end,
    output logic                     row_overflow
);
    import pngsu_pkg::*;

    localparam int DW = 8 * LANES;

    logic [DW-1:0] store_mem [MAX_ROW_PIXELS];

    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          s1_valid_reg;
    lane_bytes_t   s1_bytes_reg;
    pix_ctrl_t     s1_ctrl_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [DW-1:0] rd_reg;
    logic          fwd_hit_reg;
    logic [DW-1:0] fwd_data_reg;
    logic [DW-1:0] left_reg;
    logic          out_valid_reg;
    lane_bytes_t   out_bytes_reg;
    logic          out_end_reg;
    logic          out_ovf_reg;

    logic          s1_fire;
    logic          s1_store;
    logic [DW-1:0] pred;
    lane_bytes_t   res;
    logic [DW-1:0] res_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;

    assign busy     = clr_active_reg;
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop    = q_valid && !clr_active_reg && (!s1_valid_reg || s1_fire);
    assign s1_store = s1_fire && !s1_ctrl_reg.ovf;

    always_comb
    begin
        case (s1_ctrl_reg.pred_sel)
            PRED_LEFT:  pred = left_reg;
            PRED_STORE: pred = fwd_hit_reg ? fwd_data_reg : rd_reg;
            default:    pred = '0;
        endcase
    end

    for (genvar g = 0; g < PORT_LANES; g++)
    begin : g_lane
        if (g < LANES)
        begin : g_act
            assign res[g] = (bpp > BPP_W'(g)) ? (s1_bytes_reg[g] + pred[8*g +: 8]) : 8'd0;
            assign res_data[8*g +: 8] = res[g];
        end
        else
        begin : g_off
            assign res[g] = 8'd0;
        end
    end

    assign mem_we = clr_active_reg || s1_store;
    assign mem_wa = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wd = clr_active_reg ? '0 : res_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[mem_wa] <= mem_wd;
        if (q_pop)
            rd_reg <= store_mem[q_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_reg       <= '0;
            fwd_hit_reg    <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(MAX_ROW_PIXELS - 1))
                    clr_active_reg <= 1'b0;
            end
            if (q_pop)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_store && (s1_addr_reg == q_addr);
            end
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                left_reg      <= s1_ctrl_reg.last ? '0 : res_data;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_bytes_reg <= q_bytes;
            s1_ctrl_reg  <= q_ctrl;
            s1_addr_reg  <= q_addr;
            fwd_data_reg <= res_data;
        end
        if (s1_fire)
        begin
            out_bytes_reg <= res;
            out_end_reg   <= s1_ctrl_reg.last;
            out_ovf_reg   <= s1_ctrl_reg.ovf;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_bytes    = out_bytes_reg;
    assign row_end      = out_end_reg;
    assign row_overflow = out_ovf_reg;

`ifndef SYNTHESIS
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (!s1_valid_reg && !out_valid_reg))
        else $error("pixel in flight during store clear");
`endif

endmodule

// File: hdl/png_sub_up_row_unfilter.sv
// An accepted word passes the queue, the stage 1 registers and the output register.
// One pixel per cycle unless stalled, set by one store read and one write per cycle.
// Output register parts the two sides; a stalled output holds one word.
// Reset: bytes_per_pixel returns to 4, then the line store is cleared word by word
// with in_ready low; config writes are taken meanwhile.
module png_sub_up_row_unfilter #(
    parameter int MAX_ROW_PIXELS = pngsu_pkg::DEF_MAX_ROW_PIXELS,
    parameter int LANES = pngsu_pkg::DEF_LANES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pngsu_pkg::APB_AW-1:0] paddr,
    input  logic [pngsu_pkg::APB_DW-1:0] pwdata,
    output logic [pngsu_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  in_byte0,
    input  logic [7:0]                  in_byte1,
    input  logic [7:0]                  in_byte2,
    input  logic [7:0]                  in_byte3,
    input  logic [7:0]                  in_byte4,
    input  logic [7:0]                  in_byte5,
    input  logic [7:0]                  in_byte6,
    input  logic [7:0]                  in_byte7,
    input  logic                        filter_kind,
    input  logic                        first_row,
    input  logic                        last_in_row,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte0,
    output logic [7:0]                  out_byte1,
    output logic [7:0]                  out_byte2,
    output logic [7:0]                  out_byte3,
    output logic [7:0]                  out_byte4,
    output logic [7:0]                  out_byte5,
    output logic [7:0]                  out_byte6,
    output logic [7:0]                  out_byte7,
    output logic                        row_end,
    output logic                        row_overflow
);
    import pngsu_pkg::*;

    localparam int PW = $clog2(MAX_ROW_PIXELS + 1);
    localparam int AW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
    localparam int CW = $bits(pix_ctrl_t);
    localparam int QW = $bits(lane_bytes_t) + CW + AW;

    logic [BPP_W-1:0] bpp_reg;
    logic             cfg_wr;

    lane_bytes_t      in_bytes;
    lane_bytes_t      out_bytes;
    logic             busy;
    logic             f_push;
    lane_bytes_t      f_bytes;
    pix_ctrl_t        f_ctrl;
    logic [AW-1:0]    f_addr;
    logic             q_ready;
    logic             q_valid;
    logic             q_pop;
    logic [QW-1:0]    q_data;
    lane_bytes_t      b_bytes;
    pix_ctrl_t        b_ctrl;
    logic [AW-1:0]    b_addr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BPP);
    assign prdata = (paddr[2] == REG_BPP) ? APB_DW'(bpp_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bpp_reg <= BPP_RESET;
        else if (cfg_wr)
            bpp_reg <= pwdata[BPP_W-1:0];
    end

    assign in_bytes = {in_byte7, in_byte6, in_byte5, in_byte4,
                       in_byte3, in_byte2, in_byte1, in_byte0};

    pngsu_front #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .PW             (PW),
        .AW             (AW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_bytes    (in_bytes),
        .filter_kind (filter_kind),
        .first_row   (first_row),
        .last_in_row (last_in_row),
        .busy        (busy),
        .q_ready     (q_ready),
        .q_push      (f_push),
        .q_bytes     (f_bytes),
        .q_ctrl      (f_ctrl),
        .q_addr      (f_addr)
    );

    pngsu_fifo #(
        .W (QW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_data  ({f_bytes, f_ctrl, f_addr}),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    assign {b_bytes, b_ctrl, b_addr} = q_data;

    pngsu_back #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
        .LANES          (LANES),
        .AW             (AW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .bpp          (bpp_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_bytes      (b_bytes),
        .q_ctrl       (b_ctrl),
        .q_addr       (b_addr),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_bytes    (out_bytes),
        .row_end      (row_end),
        .row_overflow (row_overflow)
    );

    assign out_byte0 = out_bytes[0];
    assign out_byte1 = out_bytes[1];
    assign out_byte2 = out_bytes[2];
    assign out_byte3 = out_bytes[3];
    assign out_byte4 = out_bytes[4];
    assign out_byte5 = out_bytes[5];
    assign out_byte6 = out_bytes[6];
    assign out_byte7 = out_bytes[7];

endmodule

// File: tb/png_sub_up_row_unfilter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the PNG Sub/Up row unfilter with an APB width register.
module png_sub_up_row_unfilter_tb;
    import pngsu_pkg::*;

    localparam int ROW_PIXELS = DEF_MAX_ROW_PIXELS;
    localparam int NUM_LANES = DEF_LANES;
    localparam logic [APB_AW-1:0] BPP_ADDR = APB_AW'(4 * REG_BPP);
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL = 300;
    localparam int MAX_PRINTS = 40;

    typedef enum logic {
        FILT_SUB = 1'b0,
        FILT_UP  = 1'b1
    } filt_kind_t;

    typedef struct packed {
        lane_bytes_t bytes;
        filt_kind_t  kind;
        logic        first;
        logic        last;
    } pixel_word_t;

    typedef struct packed {
        lane_bytes_t bytes;
        logic        row_end;
        logic        ovf;
    } recon_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] in_byte0 = '0;
    logic [7:0] in_byte1 = '0;
    logic [7:0] in_byte2 = '0;
    logic [7:0] in_byte3 = '0;
    logic [7:0] in_byte4 = '0;
    logic [7:0] in_byte5 = '0;
    logic [7:0] in_byte6 = '0;
    logic [7:0] in_byte7 = '0;
    logic filter_kind = 1'b0;
    logic first_row = 1'b0;
    logic last_in_row = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [7:0] out_byte4;
    logic [7:0] out_byte5;
    logic [7:0] out_byte6;
    logic [7:0] out_byte7;
    logic row_end;
    logic row_overflow;

    lane_bytes_t line_mem [ROW_PIXELS] = '{default: '0};
    lane_bytes_t prev_pixel = '0;
    int unsigned col_pos = 0;
    logic [BPP_W-1:0] pix_width = BPP_RESET;

    pixel_word_t pending_pixels [$];
    recon_word_t expected_recon [$];

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_reqs = 0;
    int stall_served = 0;
    int hold_left = 0;
    int cycles = 0;

    png_sub_up_row_unfilter dut (.*);

    always #5 clk = ~clk;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic recon_word_t reconstruct_pixel(pixel_word_t p);
        recon_word_t r;
        lane_bytes_t pred;
        logic ovf;
        int i;
        ovf = (col_pos >= ROW_PIXELS);
        if (p.kind == FILT_SUB)
            pred = prev_pixel;
        else if (p.first || ovf)
            pred = '0;
        else
            pred = line_mem[col_pos];
        for (i = 0; i < PORT_LANES; i++)
            r.bytes[i] = (i < pix_width && i < NUM_LANES) ? p.bytes[i] + pred[i] : 8'h00;
        r.row_end = p.last;
        r.ovf = ovf;
        if (!ovf)
        begin
            line_mem[col_pos] = r.bytes;
            col_pos++;
        end
        if (p.last)
        begin
            col_pos = 0;
            prev_pixel = '0;
        end
        else
            prev_pixel = r.bytes;
        return r;
    endfunction

    function automatic lane_bytes_t pick_pixel();
        lane_bytes_t b;
        int i;
        for (i = 0; i < PORT_LANES; i++)
        begin
            case ($urandom_range(7))
                0: b[i] = 8'h00;
                1: b[i] = 8'hFF;
                default: b[i] = 8'($urandom);
            endcase
        end
        return b;
    endfunction

    task automatic queue_pixel(lane_bytes_t b, filt_kind_t kind, logic first, logic last);
        pixel_word_t w;
        w.bytes = b;
        w.kind = kind;
        w.first = first;
        w.last = last;
        pending_pixels.push_back(w);
    endtask

    task automatic queue_row(int len, logic mixed, filt_kind_t kind, logic first);
        int k;
        for (k = 0; k < len; k++)
            queue_pixel(pick_pixel(), mixed ? filt_kind_t'($urandom_range(1)) : kind,
                        first, k == len - 1);
    endtask

    task automatic apb_access(logic write, logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= BPP_ADDR;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_pixel_width(logic [BPP_W-1:0] width);
        logic [APB_DW-1:0] rd;
        apb_access(1'b1, APB_DW'(width), rd);
        pix_width = width;
        apb_access(1'b0, '0, rd);
        if (rd[BPP_W-1:0] !== width)
            report_mismatch("bytes_per_pixel readback", 64'(rd), 64'(width));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_pixels.size() != 0 || in_valid || expected_recon.size() != 0);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        pixel_word_t w;
        if (in_valid && in_ready)
        begin
            w.bytes = {in_byte7, in_byte6, in_byte5, in_byte4,
                       in_byte3, in_byte2, in_byte1, in_byte0};
            w.kind = filt_kind_t'(filter_kind);
            w.first = first_row;
            w.last = last_in_row;
            expected_recon.push_back(reconstruct_pixel(w));
        end
        if (rst_n && (!in_valid || in_ready))
        begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                w = pending_pixels.pop_front();
                {in_byte7, in_byte6, in_byte5, in_byte4,
                 in_byte3, in_byte2, in_byte1, in_byte0} <= w.bytes;
                filter_kind <= w.kind;
                first_row <= w.first;
                last_in_row <= w.last;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        recon_word_t want;
        lane_bytes_t got;
        int i;
        if (out_valid && out_ready)
        begin
            got = {out_byte7, out_byte6, out_byte5, out_byte4,
                   out_byte3, out_byte2, out_byte1, out_byte0};
            if (expected_recon.size() == 0)
                report_mismatch("unexpected word", got, '0);
            else
            begin
                want = expected_recon.pop_front();
                for (i = 0; i < PORT_LANES; i++)
                    if (got[i] !== want.bytes[i])
                        report_mismatch($sformatf("out_byte%0d", i), 64'(got[i]),
                                        64'(want.bytes[i]));
                if (row_end !== want.row_end)
                    report_mismatch("row_end", 64'(row_end), 64'(want.row_end));
                if (row_overflow !== want.ovf)
                    report_mismatch("row_overflow", 64'(row_overflow), 64'(want.ovf));
            end
        end
        // hold off for a long stretch on request
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_served != stall_reqs)
        begin
            hold_left <= LONG_STALL;
            stall_served <= stall_served + 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [APB_DW-1:0] rd;
        int ph;
        int n;
        int len;
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        apb_access(1'b0, '0, rd);
        if (rd[BPP_W-1:0] !== BPP_RESET)
            report_mismatch("bytes_per_pixel reset", 64'(rd), 64'(BPP_RESET));
        set_pixel_width(4'd8);

        // up on a first row adds zero, then up wraps against it
        queue_pixel('1, FILT_UP, 1'b1, 1'b0);
        queue_pixel('0, FILT_UP, 1'b1, 1'b0);
        queue_pixel({8{8'h80}}, FILT_UP, 1'b1, 1'b1);
        queue_pixel({8{8'h01}}, FILT_UP, 1'b0, 1'b0);
        queue_pixel({8{8'h01}}, FILT_UP, 1'b0, 1'b0);
        queue_pixel({8{8'h01}}, FILT_UP, 1'b0, 1'b1);
        queue_pixel('1, FILT_SUB, 1'b0, 1'b0);
        queue_pixel({8{8'h01}}, FILT_SUB, 1'b0, 1'b0);
        queue_pixel('1, FILT_SUB, 1'b0, 1'b0);
        queue_pixel('1, FILT_SUB, 1'b0, 1'b1);
        queue_pixel(pick_pixel(), FILT_SUB, 1'b0, 1'b0);
        queue_pixel(pick_pixel(), FILT_UP, 1'b0, 1'b0);
        queue_pixel(pick_pixel(), FILT_SUB, 1'b0, 1'b0);
        queue_pixel(pick_pixel(), FILT_UP, 1'b0, 1'b1);
        queue_pixel(pick_pixel(), FILT_UP, 1'b0, 1'b1);
        wait_drained();
        set_pixel_width(4'd0);
        queue_row(2, 1'b1, FILT_SUB, 1'b0);
        wait_drained();
        set_pixel_width(4'd15);
        queue_pixel(pick_pixel(), FILT_SUB, 1'b0, 1'b0);
        queue_pixel(pick_pixel(), FILT_UP, 1'b0, 1'b1);
        wait_drained();
        set_pixel_width(4'd1);
        queue_pixel(pick_pixel(), FILT_UP, 1'b0, 1'b0);
        queue_pixel(pick_pixel(), FILT_SUB, 1'b0, 1'b1);

        for (ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            set_pixel_width(ph == 4 ? 4'd8 : 4'($urandom_range(15)));
            send_idle_pct = ph < 2 ? 25 : (ph < 4 ? 66 : 0);
            recv_idle_pct = ph < 2 ? 66 : (ph < 4 ? 25 : 0);
            n = 0;
            while (n < 85)
            begin
                if ($urandom_range(9) < 8)
                begin
                    len = $urandom_range(1, 12);
                    queue_row(len, $urandom_range(3) == 0, filt_kind_t'($urandom_range(1)),
                              $urandom_range(5) == 0);
                    n += len;
                end
                else
                begin
                    queue_pixel(pick_pixel(), filt_kind_t'($urandom_range(1)),
                                1'($urandom_range(1)), 1'($urandom_range(1)));
                    n++;
                end
            end
            if (ph == 0 || ph == 4)
                stall_reqs++;
        end

        // run one row past the line store, then read it back with up
        wait_drained();
        set_pixel_width(4'd8);
        for (k = 0; k < ROW_PIXELS; k++)
            queue_pixel(pick_pixel(), filt_kind_t'($urandom_range(1)), 1'b0, 1'b0);
        queue_pixel(pick_pixel(), FILT_UP, 1'b0, 1'b0);
        queue_pixel(pick_pixel(), FILT_SUB, 1'b0, 1'b0);
        queue_pixel(pick_pixel(), FILT_UP, 1'b0, 1'b1);
        queue_row(6, 1'b0, FILT_UP, 1'b0);
        wait_drained();

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
hdl/pngsu_pkg.sv
hdl/pngsu_front.sv
hdl/pngsu_fifo.sv
hdl/pngsu_back.sv
hdl/png_sub_up_row_unfilter.sv
tb/png_sub_up_row_unfilter_tb.sv
